>>> rtl/lkhc_pkg.sv
// lkhc_pkg: shared types, widths and register codes of the keyed handle cache
// no dependencies; imported by every module of the block

package lkhc_pkg;

	// field widths
	localparam int KEY_W    = 64;
	localparam int HANDLE_W = 64;
	localparam int LEN_W    = 31;
	localparam int SLOT_W   = 4;

	// default sizing
	localparam int ENTRIES_DEF    = 16;
	localparam int COUNT_BITS_DEF = 16;

	// stream payload widths, padded to whole bytes
	localparam int IN_TDATA_W  = 160;
	localparam int OUT_TDATA_W = 104;

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_BUILTIN_A = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BUILTIN_B = CFG_IDX_W'(1);

	localparam logic [KEY_W-1:0] BUILTIN_A_RST = KEY_W'(1);
	localparam logic [KEY_W-1:0] BUILTIN_B_RST = KEY_W'(2);

	// one stored entry apart from its use count
	typedef struct packed {
		logic [LEN_W-1:0]    length;
		logic [HANDLE_W-1:0] handle;
		logic [KEY_W-1:0]    key;
	} entry_t;

	// request beat after unpacking
	typedef struct packed {
		logic                fill_failed;
		logic [LEN_W-1:0]    fill_length;
		logic [HANDLE_W-1:0] fill_handle;
		logic [KEY_W-1:0]    key;
	} req_t;

	// result beat before packing
	typedef struct packed {
		logic                failed;
		logic [LEN_W-1:0]    length_out;
		logic [HANDLE_W-1:0] handle;
		logic [SLOT_W-1:0]   slot;
		logic                builtin;
		logic                hit;
	} rsp_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CHECK  = 5'b00010,
		ST_READ   = 5'b00100,
		ST_CMP    = 5'b01000,
		ST_UPDATE = 5'b10000
	} state_t;

endpackage

>>> rtl/lfu_keyed_handle_cache.sv
// lfu_keyed_handle_cache: top level of the keyed handle cache
// depends on lkhc_pkg, lkhc_store and lkhc_ctrl
//
// A fully associative cache of ENTRIES image handles with least-frequently-used
// replacement. Each request beat is taken only when the block is idle; its key is
// first checked against the two built-in keys (result registered in the check
// state, cache untouched), otherwise the entries are scanned in index order through
// one registered memory read port and a single comparator, a read and a compare
// state per entry. A hit ends the scan at its entry; a miss scans every entry and
// replaces the lowest-count entry, lowest index on a tie. The next request is taken
// in the cycle after the result is loaded, even while that result still waits for
// m_tready. Entries start empty with key 0 and need no clearing pass. Configuration
// writes are always accepted and must be issued only while no request is in flight.

module lfu_keyed_handle_cache #(
	parameter int ENTRIES    = lkhc_pkg::ENTRIES_DEF,
	parameter int COUNT_BITS = lkhc_pkg::COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lkhc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lkhc_pkg::CFG_DATA_W-1:0]      cfg_data,
	// request stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// key[63:0], fill_handle[127:64], fill_length[158:128], fill_failed[159]
	input  logic [lkhc_pkg::IN_TDATA_W-1:0]      s_tdata,
	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// hit[0], builtin[1], slot[5:2], handle[69:6], length_out[100:70],
	// failed[101], zero[103:102]
	output logic [lkhc_pkg::OUT_TDATA_W-1:0]     m_tdata
);
	import lkhc_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);

	req_t                  req;
	rsp_t                  rsp;
	logic [IDX_W-1:0]      rd_addr;
	entry_t                rd_entry;
	logic [COUNT_BITS-1:0] rd_count;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	entry_t                wr_entry;
	logic [COUNT_BITS-1:0] wr_count;

	// configuration writes never stall
	assign cfg_ready = 1'b1;

	// beat unpacking and packing
	assign req     = req_t'(s_tdata[$bits(req_t)-1:0]);
	assign m_tdata = OUT_TDATA_W'(rsp);

	lkhc_ctrl #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.rsp_valid (m_tvalid),
		.rsp_ready (m_tready),
		.rsp       (rsp),
		.rd_addr   (rd_addr),
		.rd_entry  (rd_entry),
		.rd_count  (rd_count),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_entry  (wr_entry),
		.wr_count  (wr_count)
	);

	lkhc_store #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.rd_count (rd_count),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry),
		.wr_count (wr_count)
	);

endmodule

>>> rtl/lkhc_store.sv
// lkhc_store: entry memories with one registered read port and one write port
// depends on lkhc_pkg; entries not yet written read back as all zero

module lkhc_store #(
	parameter int ENTRIES    = lkhc_pkg::ENTRIES_DEF,
	parameter int COUNT_BITS = lkhc_pkg::COUNT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [$clog2(ENTRIES)-1:0] rd_addr,
	output lkhc_pkg::entry_t           rd_entry,
	output logic [COUNT_BITS-1:0]      rd_count,
	input  logic                       wr_en,
	input  logic [$clog2(ENTRIES)-1:0] wr_addr,
	input  lkhc_pkg::entry_t           wr_entry,
	input  logic [COUNT_BITS-1:0]      wr_count
);
	import lkhc_pkg::*;

	entry_t                entry_mem [ENTRIES];
	logic [COUNT_BITS-1:0] count_mem [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;

	entry_t                rd_entry_q;
	logic [COUNT_BITS-1:0] rd_count_q;
	logic                  rd_valid_q;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= wr_entry;
			count_mem[wr_addr] <= wr_count;
		end
		rd_entry_q <= entry_mem[rd_addr];
		rd_count_q <= count_mem[rd_addr];
		rd_valid_q <= valid_q[rd_addr];
	end

	// written marks, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// unwritten entries look like reset entries
	assign rd_entry = rd_valid_q ? rd_entry_q : '0;
	assign rd_count = rd_valid_q ? rd_count_q : '0;

endmodule

>>> rtl/lkhc_ctrl.sv
// lkhc_ctrl: built-in key registers, scan sequencer with one shared comparator,
// and the result register; depends on lkhc_pkg and drives lkhc_store

module lkhc_ctrl #(
	parameter int ENTRIES    = lkhc_pkg::ENTRIES_DEF,
	parameter int COUNT_BITS = lkhc_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes
	input  logic                                cfg_we,
	input  logic [lkhc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [lkhc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// request side
	input  logic                                req_valid,
	output logic                                req_ready,
	input  lkhc_pkg::req_t                      req,
	// result side
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output lkhc_pkg::rsp_t                      rsp,
	// entry store
	output logic [$clog2(ENTRIES)-1:0]          rd_addr,
	input  lkhc_pkg::entry_t                    rd_entry,
	input  logic [COUNT_BITS-1:0]               rd_count,
	output logic                                wr_en,
	output logic [$clog2(ENTRIES)-1:0]          wr_addr,
	output lkhc_pkg::entry_t                    wr_entry,
	output logic [COUNT_BITS-1:0]               wr_count
);
	import lkhc_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(ENTRIES - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
	localparam rsp_t RSP_BUILTIN = '{failed: 1'b0, length_out: '0, handle: '0, slot: '0,
		builtin: 1'b1, hit: 1'b0};

	state_t                state_q;
	logic [KEY_W-1:0]      builtin_a_q;
	logic [KEY_W-1:0]      builtin_b_q;
	req_t                  req_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      victim_q;
	logic [COUNT_BITS-1:0] min_q;
	logic                  hit_q;
	entry_t                hit_entry_q;
	logic [COUNT_BITS-1:0] hit_count_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic                  out_free;
	logic                  rsp_load;
	logic                  is_builtin;
	logic                  key_match;
	logic                  new_min;
	logic [COUNT_BITS-1:0] hit_count_next;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rd_addr   = idx_q;

	// built-in key compare against both key registers in parallel
	assign is_builtin = (req_q.key == builtin_a_q) || (req_q.key == builtin_b_q);

	// result register loads on a built-in bypass or at the end of the update
	assign rsp_load = out_free
		&& (((state_q == ST_CHECK) && is_builtin) || (state_q == ST_UPDATE));

	// shared compare unit: key match and minimum search
	assign key_match = (rd_entry.key == req_q.key);
	assign new_min   = (idx_q == '0) || (rd_count < min_q);

	// saturating use count
	assign hit_count_next = (hit_count_q == COUNT_MAX) ? hit_count_q
		: hit_count_q + COUNT_ONE;

	// entry write on update
	always_comb begin
		wr_en    = (state_q == ST_UPDATE) && out_free;
		wr_addr  = victim_q;
		wr_entry = '0;
		wr_entry.key = req_q.key;
		if (hit_q) begin
			wr_entry.handle = hit_entry_q.handle;
			wr_entry.length = hit_entry_q.length;
			wr_count        = hit_count_next;
		end else begin
			wr_entry.handle = req_q.fill_handle;
			wr_entry.length = req_q.fill_length;
			wr_count        = COUNT_ONE;
		end
	end

	// built-in key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			builtin_a_q <= BUILTIN_A_RST;
			builtin_b_q <= BUILTIN_B_RST;
		end else if (cfg_we) begin
			if (cfg_idx == REG_BUILTIN_A) begin
				builtin_a_q <= cfg_wdata;
			end
			if (cfg_idx == REG_BUILTIN_B) begin
				builtin_b_q <= cfg_wdata;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (!is_builtin) begin
						state_q <= ST_READ;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (key_match || idx_q == LAST_IDX) begin
						state_q <= ST_UPDATE;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_UPDATE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_q <= req;
				end
				idx_q <= '0;
				hit_q <= 1'b0;
			end
			ST_CHECK: begin
				if (is_builtin && out_free) begin
					rsp_q <= RSP_BUILTIN;
				end
			end
			ST_READ: begin
			end
			ST_CMP: begin
				if (key_match) begin
					hit_q       <= 1'b1;
					victim_q    <= idx_q;
					hit_entry_q <= rd_entry;
					hit_count_q <= rd_count;
				end else begin
					if (new_min) begin
						min_q    <= rd_count;
						victim_q <= idx_q;
					end
					if (idx_q != LAST_IDX) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
			end
			ST_UPDATE: begin
				if (out_free) begin
					rsp_q.hit     <= hit_q;
					rsp_q.builtin <= 1'b0;
					rsp_q.slot    <= SLOT_W'(victim_q);
					if (hit_q) begin
						rsp_q.handle     <= hit_entry_q.handle;
						rsp_q.length_out <= hit_entry_q.length;
						rsp_q.failed     <= 1'b0;
					end else begin
						rsp_q.handle     <= req_q.fill_handle;
						rsp_q.length_out <= req_q.fill_length;
						rsp_q.failed     <= req_q.fill_failed;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/lkhc_checker.sv
// lkhc_checker: port-level assertions for the keyed handle cache, bound to the top
// depends on lkhc_pkg for the stream widths

module lkhc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [lkhc_pkg::IN_TDATA_W-1:0]  s_tdata,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [lkhc_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import lkhc_pkg::*;

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// one request in flight: no back-to-back accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// built-in result carries nothing else
	a_builtin_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[0] == 1'b0 && m_tdata[101:2] == '0)
		else $error("built-in result with payload");

	// a hit is never built-in and never failed
	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[1] && !m_tdata[101])
		else $error("hit result with built-in or failed flag");

endmodule

bind lfu_keyed_handle_cache lkhc_checker u_lkhc_checker (.*);

>>> tb/tb.sv
// tb: self-checking bench for lfu_keyed_handle_cache, stream request and result ports
// depends on lkhc_pkg and the rtl of the cache; a built-in lookup model predicts each result

`timescale 1ns / 1ps

module tb;
	import lkhc_pkg::*;

	localparam int RSP_W = $bits(rsp_t);
	localparam int POOL_SIZE = 24;
	localparam int STALL_CYCLES = 300;
	localparam int MAX_REPORTS = 10;
	localparam int HOT_HITS = 300;
	localparam logic [COUNT_BITS_DEF-1:0] COUNT_MAX = '1;
	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// lookup model state and its copy of the registers
	logic [KEY_W-1:0] builtin_key_a = BUILTIN_A_RST;
	logic [KEY_W-1:0] builtin_key_b = BUILTIN_B_RST;
	logic [KEY_W-1:0] cache_keys [ENTRIES_DEF];
	logic [HANDLE_W-1:0] cache_handles [ENTRIES_DEF];
	logic [LEN_W-1:0] cache_lengths [ENTRIES_DEF];
	logic [COUNT_BITS_DEF-1:0] use_counts [ENTRIES_DEF];

	req_t queued_reqs[$];
	rsp_t predicted_rsps[$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	int tx_idle_pct = 21;
	int rx_idle_pct = 78;
	int stall_requests = 0;
	int stall_seen = 0;
	int stall_left = 0;
	int cfg_beats = 0;
	int mismatch_count = 0;
	bit s_took = 1'b0;

	lfu_keyed_handle_cache u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// register write as the block applies it
	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		if (idx == REG_BUILTIN_A) begin
			builtin_key_a = val;
		end else if (idx == REG_BUILTIN_B) begin
			builtin_key_b = val;
		end
	endfunction

	// one lookup: built-in bypass, hit with saturating count, or lfu replacement
	function automatic rsp_t cache_lookup(req_t req);
		rsp_t res;
		int found;
		int victim;
		res = '0;
		found = -1;
		victim = 0;
		if (req.key == builtin_key_a || req.key == builtin_key_b) begin
			res.builtin = 1'b1;
			return res;
		end
		for (int i = 0; i < ENTRIES_DEF; i++) begin
			if (found < 0 && cache_keys[i] == req.key) found = i;
		end
		if (found >= 0) begin
			if (use_counts[found] != COUNT_MAX) use_counts[found] = use_counts[found] + 1'b1;
			res.hit = 1'b1;
			res.slot = SLOT_W'(found);
			res.handle = cache_handles[found];
			res.length_out = cache_lengths[found];
			return res;
		end
		// lowest count wins, lowest index on a tie
		for (int i = 1; i < ENTRIES_DEF; i++) begin
			if (use_counts[i] < use_counts[victim]) victim = i;
		end
		cache_keys[victim] = req.key;
		cache_handles[victim] = req.fill_handle;
		cache_lengths[victim] = req.fill_length;
		use_counts[victim] = COUNT_BITS_DEF'(1);
		res.slot = SLOT_W'(victim);
		res.handle = req.fill_handle;
		res.length_out = req.fill_length;
		res.failed = req.fill_failed;
		return res;
	endfunction

	function automatic void queue_req(logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] handle,
			logic [LEN_W-1:0] len, logic failed);
		req_t req;
		req.key = key;
		req.fill_handle = handle;
		req.fill_length = len;
		req.fill_failed = failed;
		queued_reqs.push_back(req);
	endfunction

	// mostly pooled keys so hits and evictions both happen, some built-ins, empty and fresh keys
	task automatic add_random_reqs(int n);
		logic [KEY_W-1:0] key;
		int pick;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 62) begin
				key = key_pool[$urandom_range(POOL_SIZE - 1)];
			end else if (pick < 70) begin
				key = pick[0] ? builtin_key_a : builtin_key_b;
			end else if (pick < 76) begin
				key = '0;
			end else begin
				key = {$urandom(), $urandom()};
			end
			queue_req(key, {$urandom(), $urandom()}, LEN_W'($urandom()), 1'($urandom_range(1)));
		end
	endtask

	// settle after the falling edge so queue sizes and valid are stable
	task automatic wait_idle();
		do begin
			@(negedge clk);
			#1;
		end while (queued_reqs.size() != 0 || predicted_rsps.size() != 0 || s_tvalid);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		int target;
		@(negedge clk);
		target = cfg_beats + 1;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (cfg_beats < target);
		cfg_valid <= 1'b0;
	endtask

	// request driver: hold until the beat is taken, then maybe idle
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !s_took)) begin
			if (queued_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= queued_reqs.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver with random back-pressure and an occasional long hold-off
	always @(negedge clk) begin
		if (stall_seen != stall_requests) begin
			stall_seen <= stall_requests;
			stall_left <= STALL_CYCLES;
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// monitor: register writes, request beats into the model, result beats checked
	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		logic [OUT_TDATA_W-RSP_W-1:0] pad;
		if (arst_n) begin
			s_took = s_tvalid && s_tready;
			if (cfg_valid && cfg_ready) begin
				cfg_beats++;
				apply_register(cfg_index, cfg_data);
			end
			if (m_tvalid && m_tready) begin
				got = rsp_t'(m_tdata[RSP_W-1:0]);
				pad = m_tdata[OUT_TDATA_W-1:RSP_W];
				if (predicted_rsps.size() == 0) begin
					if (mismatch_count < MAX_REPORTS)
						$display("%0t: result beat with nothing outstanding: %h", $realtime, m_tdata);
					mismatch_count++;
				end else begin
					want = predicted_rsps.pop_front();
					if (got !== want || pad !== '0) begin
						if (mismatch_count < MAX_REPORTS) begin
							$display("%0t: exp hit=%0b builtin=%0b slot=%0d handle=%h len=%h failed=%0b",
								$realtime, want.hit, want.builtin, want.slot, want.handle,
								want.length_out, want.failed);
							$display("%0t: got hit=%0b builtin=%0b slot=%0d handle=%h len=%h failed=%0b pad=%b",
								$realtime, got.hit, got.builtin, got.slot, got.handle,
								got.length_out, got.failed, pad);
						end
						mismatch_count++;
					end
				end
			end
			if (s_tvalid && s_tready) predicted_rsps.push_back(cache_lookup(req_t'(s_tdata)));
		end
	end

	// main sequence
	initial begin
		logic [KEY_W-1:0] hot_key;
		logic [KEY_W-1:0] shared_key;
		int hot_hits;
		for (int i = 0; i < ENTRIES_DEF; i++) begin
			cache_keys[i] = '0;
			cache_handles[i] = '0;
			cache_lengths[i] = '0;
			use_counts[i] = '0;
		end
		for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom(), $urandom()};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset keys, empty name, extremes, failed fill, fill-up and ties
		queue_req('0, 64'hDEAD_BEEF_0BAD_F00D, LEN_W'(5), 1'b1);
		queue_req(BUILTIN_A_RST, '1, '1, 1'b1);
		queue_req(BUILTIN_B_RST, '1, '1, 1'b1);
		queue_req('1, '1, '1, 1'b1);
		queue_req('1, '0, '0, 1'b0);
		queue_req(64'h8000_0000_0000_0000, '0, '0, 1'b0);
		queue_req('0, '1, '1, 1'b0);
		for (int i = 0; i < 13; i++)
			queue_req(64'hA5A5_5A5A_0000_0000 | i, {$urandom(), $urandom()}, LEN_W'($urandom()), 1'(i));
		queue_req(64'h0123_4567_89AB_CDEF, 64'h5555_AAAA_5555_AAAA, LEN_W'(31'h2AAA_AAAA), 1'b0);
		queue_req(64'h8000_0000_0000_0000, 64'hAAAA_5555_AAAA_5555, LEN_W'(31'h5555_5555), 1'b1);
		wait_idle();

		// extremes: all-ones and zero keys bypass
		cfg_write(REG_BUILTIN_A, '1);
		cfg_write(REG_BUILTIN_B, '0);
		add_random_reqs(310);
		wait_idle();

		// a pooled key turns built-in while it may sit in the cache
		tx_idle_pct = 78;
		rx_idle_pct = 21;
		cfg_write(REG_BUILTIN_A, key_pool[3]);
		cfg_write(REG_BUILTIN_B, {$urandom(), $urandom()});
		add_random_reqs(310);
		wait_idle();

		// equal keys, writes to unused indexes, no idling and a long result hold-off
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		shared_key = {$urandom(), $urandom()};
		cfg_write(REG_BUILTIN_A, shared_key);
		cfg_write(REG_BUILTIN_B, shared_key);
		cfg_write(REG_SPARE, '0);
		cfg_write(REG_SPARE_TOP, '0);
		add_random_reqs(310);
		while (queued_reqs.size() > 250) @(negedge clk);
		stall_requests++;
		wait_idle();

		// push entry 0 to a high count, then misses must not pick it
		hot_key = cache_keys[0];
		cfg_write(REG_BUILTIN_A, hot_key + 64'd1);
		cfg_write(REG_BUILTIN_B, hot_key + 64'd2);
		hot_hits = HOT_HITS;
		for (int i = 0; i < hot_hits; i++) queue_req(hot_key, '0, '0, 1'b1);
		for (int i = 0; i < 8; i++)
			queue_req({$urandom(), $urandom()}, {$urandom(), $urandom()}, LEN_W'($urandom()), 1'b0);
		wait_idle();

		// drain: allow stray beats to show up
		repeat (40) @(negedge clk);
		if (mismatch_count == 0 && predicted_rsps.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#50_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
